// ----- src/pdvc_pkg.sv -----
package pdvc_pkg;

   // Field widths
   localparam int SPEED_BITS = 12;
   localparam int FRAC_BITS  = 24;
   localparam int GAIN_BITS  = 24;
   localparam int START_BITS = 13;
   localparam int DRIVE_BITS = 7;

   // Derived datapath widths
   localparam int ERR_BITS   = SPEED_BITS + 1;
   localparam int DELTA_BITS = ERR_BITS + 1;
   localparam int ACC_BITS   = DRIVE_BITS + FRAC_BITS;
   localparam int SUM_BITS   = DELTA_BITS + GAIN_BITS + 2;

   // Drive ceiling, integer part only
   localparam int DRIVE_MAX = 127;

   localparam logic [ACC_BITS-1:0] ACC_TOP = ACC_BITS'(DRIVE_MAX) << FRAC_BITS;
   localparam logic signed [SUM_BITS-1:0] SUM_TOP = SUM_BITS'(DRIVE_MAX) << FRAC_BITS;

   // Register reset values
   localparam logic [GAIN_BITS-1:0] PROP_GAIN_RESET  = GAIN_BITS'(3355);
   localparam logic [GAIN_BITS-1:0] DERIV_GAIN_RESET = GAIN_BITS'(2516582);
   localparam logic signed [START_BITS-1:0] START_PREV_ERROR_RESET = START_BITS'(3000);
   localparam logic signed [ERR_BITS-1:0] PREV_ERROR_RESET = ERR_BITS'(START_PREV_ERROR_RESET);

   // Control register port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = GAIN_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PROP_GAIN        = 2'd0,
      CSR_DERIV_GAIN       = 2'd1,
      CSR_START_PREV_ERROR = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_BITS-1:0]         prop_gain;
      logic [GAIN_BITS-1:0]         deriv_gain;
      logic signed [START_BITS-1:0] start_prev_error;
   } cfg_type;

endpackage

// ----- src/pdvc_csr.sv -----
module pdvc_csr
   import pdvc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [CSR_INDEX_BITS-1:0] wr_index,
   input  logic [CSR_DATA_BITS-1:0]  wr_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_PROP_GAIN:        cfg_in.prop_gain = wr_data[GAIN_BITS-1:0];
            CSR_DERIV_GAIN:       cfg_in.deriv_gain = wr_data[GAIN_BITS-1:0];
            CSR_START_PREV_ERROR: cfg_in.start_prev_error = wr_data[START_BITS-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain        <= PROP_GAIN_RESET;
         cfg_ff.deriv_gain       <= DERIV_GAIN_RESET;
         cfg_ff.start_prev_error <= START_PREV_ERROR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/pdvc_datapath.sv -----
module pdvc_datapath
   import pdvc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [SPEED_BITS-1:0] measured_rpm,
   input  logic [SPEED_BITS-1:0] target_rpm,
   input  cfg_type               cfg,
   output logic [DRIVE_BITS-1:0] drive_next
);

   logic signed [ERR_BITS-1:0]   prev_error_ff;
   logic signed [ERR_BITS-1:0]   prev_error_in;
   logic [ACC_BITS-1:0]          drive_accum_ff;
   logic [ACC_BITS-1:0]          drive_accum_in;

   logic signed [ERR_BITS-1:0]   err;
   logic signed [DELTA_BITS-1:0] delta;
   logic signed [SUM_BITS-1:0]   err_w;
   logic signed [SUM_BITS-1:0]   delta_w;
   logic signed [SUM_BITS-1:0]   kp_w;
   logic signed [SUM_BITS-1:0]   kd_w;
   logic signed [SUM_BITS-1:0]   accum_w;
   logic signed [SUM_BITS-1:0]   sum;
   logic [ACC_BITS-1:0]          clamped;
   logic                         target_zero;

   assign err     = $signed({1'b0, target_rpm}) - $signed({1'b0, measured_rpm});
   assign delta   = DELTA_BITS'(err) - DELTA_BITS'(prev_error_ff);
   assign err_w   = SUM_BITS'(err);
   assign delta_w = SUM_BITS'(delta);
   assign kp_w    = SUM_BITS'($signed({1'b0, cfg.prop_gain}));
   assign kd_w    = SUM_BITS'($signed({1'b0, cfg.deriv_gain}));
   assign accum_w = SUM_BITS'($signed({1'b0, drive_accum_ff}));

   // velocity form: accumulate P on error plus D on error change
   assign sum = accum_w + err_w * kp_w + delta_w * kd_w;

   always_comb begin
      if (sum > SUM_TOP) begin
         clamped = ACC_TOP;
      end else if (sum[SUM_BITS-1]) begin
         clamped = '0;
      end else begin
         clamped = sum[ACC_BITS-1:0];
      end
   end

   assign target_zero = (target_rpm == '0);

   always_comb begin
      prev_error_in  = prev_error_ff;
      drive_accum_in = drive_accum_ff;
      if (step) begin
         if (target_zero) begin
            prev_error_in  = ERR_BITS'(cfg.start_prev_error);
            drive_accum_in = '0;
         end else begin
            prev_error_in  = err;
            drive_accum_in = clamped;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff  <= PREV_ERROR_RESET;
         drive_accum_ff <= '0;
      end else begin
         prev_error_ff  <= prev_error_in;
         drive_accum_ff <= drive_accum_in;
      end
   end

   assign drive_next = drive_accum_in[ACC_BITS-1:FRAC_BITS];

`ifndef SYNTHESIS
   a_accum_ceiling: assert property (@(posedge clock) disable iff (reset)
      drive_accum_ff <= ACC_TOP)
      else $error("accumulator above drive ceiling");

   a_zero_target: assert property (@(posedge clock) disable iff (reset)
      step && target_zero |=> drive_accum_ff == '0 &&
         prev_error_ff == ERR_BITS'($past(cfg.start_prev_error)))
      else $error("zero target did not clear state");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(drive_accum_ff) && $stable(prev_error_ff))
      else $error("state changed without a step");

   a_prev_tracks: assert property (@(posedge clock) disable iff (reset)
      step && !target_zero |=> prev_error_ff == $past(err))
      else $error("previous error not updated");
`endif

endmodule

// ----- src/incremental_pd_velocity_control.sv -----
// Velocity-form PD speed controller for a flywheel drive.
//
// Request channel (req_*): one beat carries a measured speed and the target
// speed. Each request beat yields exactly one response beat (rsp_drive, 0..127)
// in request order.
// Control port (csr_*): always ready; index 0 = proportional gain, 1 =
// derivative gain (both unsigned, 24 fraction bits), 2 = start value of the
// previous error (signed). Other indexes are dropped. Write only while idle.
//
// Path: a request beat passes the input register, then the gain
// multiply-accumulate and clamp into the response register.
// Throughput: one beat per cycle unless the response stalls.
//
// Reset (synchronous): gains and start value return to defaults, accumulator
// clears, previous error loads the start value, both pipeline stages empty.
// A zero target drives 0 and reloads the previous error from the start value.
// Response stall: the response register holds; the input register still
// takes one more beat, then req_stall rises until the response moves.
module incremental_pd_velocity_control
   import pdvc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [SPEED_BITS-1:0]     req_measured_rpm,
   input  logic [SPEED_BITS-1:0]     req_target_rpm,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [DRIVE_BITS-1:0]     rsp_drive,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   cfg_type cfg;

   // input stage
   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [SPEED_BITS-1:0] in_measured_ff;
   logic [SPEED_BITS-1:0] in_target_ff;

   // response stage
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DRIVE_BITS-1:0] rsp_drive_ff;
   logic [DRIVE_BITS-1:0] drive_next;

   logic out_move;
   logic step;
   logic req_take;

   assign csr_ready = 1'b1;

   pdvc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // response register free or emptying this cycle
   assign out_move  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_move;
   assign req_stall = in_valid_ff && !out_move;
   assign req_take  = req_valid && !req_stall;

   pdvc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .measured_rpm (in_measured_ff),
      .target_rpm   (in_target_ff),
      .cfg          (cfg),
      .drive_next   (drive_next)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_move) begin
         rsp_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_measured_ff <= req_measured_rpm;
         in_target_ff   <= req_target_rpm;
      end
      if (step) begin
         rsp_drive_ff <= drive_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

`ifndef SYNTHESIS
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall && in_valid_ff)
      else $error("request stalled without a blocked response");

   a_step_fills: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("step did not produce a response");

   a_blocked_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_move |=> in_valid_ff && $stable(in_target_ff))
      else $error("input stage lost a blocked beat");
`endif

endmodule

// ----- sim/incremental_pd_velocity_control_tb.sv -----
module incremental_pd_velocity_control_tb;
   import pdvc_pkg::*;

   localparam int CLK_HALF     = 5;
   localparam int MAX_SPEED    = (1 << SPEED_BITS) - 1;
   localparam int MAX_REPORTS  = 10;
   localparam int RUN_PHASES   = 8;
   localparam int PHASE_BEATS  = 240;
   localparam int DRAIN_CYCLES = 20000;
   localparam int TAIL_CYCLES  = 10;
   localparam longint ACC_CEIL = longint'(DRIVE_MAX) << FRAC_BITS;
   // index 3 decodes to nothing; writes there must be dropped
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = 2'd3;

   // ------------------------------------------------------------------
   // DUT ports; every input starts at a known value
   // ------------------------------------------------------------------
   logic                      clock;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_stall;
   logic [SPEED_BITS-1:0]     req_measured_rpm = '0;
   logic [SPEED_BITS-1:0]     req_target_rpm   = '0;
   logic                      rsp_valid;
   logic                      rsp_stall        = 1'b0;
   logic [DRIVE_BITS-1:0]     rsp_drive;
   logic                      csr_valid        = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index        = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data         = '0;

   incremental_pd_velocity_control u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_measured_rpm (req_measured_rpm),
      .req_target_rpm   (req_target_rpm),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_drive        (rsp_drive),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      clock = 1'b0;
      #CLK_HALF;
      clock = 1'b1;
      #CLK_HALF;
   end

   // ------------------------------------------------------------------
   // Controller model: register copy plus the two pieces of loop state
   // ------------------------------------------------------------------
   cfg_type                 model_cfg;
   int                      model_prev_err;
   longint                  model_accum;      // Q7.FRAC_BITS, kept wide
   logic [DRIVE_BITS-1:0]   drive_q[$];       // expected drive per request beat
   logic [DRIVE_BITS-1:0]   expected_drive;
   int                      fail_count  = 0;
   int                      rsp_beats   = 0;
   bit                      no_req_gaps = 1'b0;

   task automatic model_reset();
      model_cfg.prop_gain        = PROP_GAIN_RESET;
      model_cfg.deriv_gain       = DERIV_GAIN_RESET;
      model_cfg.start_prev_error = START_PREV_ERROR_RESET;
      model_prev_err             = int'(START_PREV_ERROR_RESET);
      model_accum                = 0;
   endtask

   // Register write as the block sees it. Start value is only latched here;
   // prev error picks it up at the next zero target.
   task automatic apply_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_PROP_GAIN:        model_cfg.prop_gain        = data[GAIN_BITS-1:0];
         CSR_DERIV_GAIN:       model_cfg.deriv_gain       = data[GAIN_BITS-1:0];
         CSR_START_PREV_ERROR: model_cfg.start_prev_error = data[START_BITS-1:0];
         default: ;
      endcase
   endtask

   // One velocity-form PD update: accum += e*kp + (e - e_prev)*kd, clamp
   // to 0..127.0, zero target forces drive off and reloads prev error.
   function automatic logic [DRIVE_BITS-1:0] predict_drive(
      input logic [SPEED_BITS-1:0] meas, input logic [SPEED_BITS-1:0] tgt);
      int     err;
      int     delta;
      longint sum;
      err   = int'(tgt) - int'(meas);
      delta = err - model_prev_err;
      sum   = model_accum + longint'(err) * longint'(model_cfg.prop_gain)
            + longint'(delta) * longint'(model_cfg.deriv_gain);
      if (sum > ACC_CEIL) begin
         sum = ACC_CEIL;
      end else if (sum < 0) begin
         sum = 0;
      end
      model_prev_err = err;
      model_accum    = sum;
      if (tgt == '0) begin
         model_accum    = 0;
         model_prev_err = int'(model_cfg.start_prev_error);
      end
      return DRIVE_BITS'(model_accum >>> FRAC_BITS);
   endfunction

   task automatic flag_failure(input string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("mismatch %0d: %s", fail_count, what);
      end
   endtask

   // ------------------------------------------------------------------
   // Response side: random stall bursts, mostly short, some long, with
   // occasional long quiet stretches
   // ------------------------------------------------------------------
   function automatic int pick_stall_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 1;
      if (r < 90) return $urandom_range(2, 4);
      if (r < 97) return $urandom_range(5, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      wait (reset === 1'b0);
      forever begin
         repeat (($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                             : $urandom_range(1, 30))
            @(negedge clock) rsp_stall = 1'b0;
         repeat (pick_stall_len()) @(negedge clock) rsp_stall = 1'b1;
      end
   end

   // Every response beat is checked against the oldest prediction
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         rsp_beats++;
         if (drive_q.size() == 0) begin
            flag_failure($sformatf("response beat %0d with nothing pending, drive %0d",
                                   rsp_beats, rsp_drive));
         end else begin
            expected_drive = drive_q.pop_front();
            if (rsp_drive !== expected_drive) begin
               flag_failure($sformatf("beat %0d drive expected %0d got %0d",
                                      rsp_beats, expected_drive, rsp_drive));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   function automatic int pick_req_gap();
      int r;
      if (no_req_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Present one request beat after an optional gap. Valid stays high on
   // return so back-to-back beats never drop it; drain_and_idle lowers it.
   task automatic send_beat(input logic [SPEED_BITS-1:0] meas,
                            input logic [SPEED_BITS-1:0] tgt,
                            input int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid        = 1'b0;
         req_measured_rpm = SPEED_BITS'($urandom);
         req_target_rpm   = SPEED_BITS'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        = 1'b1;
      req_measured_rpm = meas;
      req_target_rpm   = tgt;
      do @(posedge clock); while (req_stall !== 1'b0);
      drive_q.push_back(predict_drive(meas, tgt));
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      apply_csr(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Stop requests and let every pending response come back; anything
   // still pending after the bound is reported and dropped.
   task automatic drain_and_idle();
      @(negedge clock);
      req_valid = 1'b0;
      for (int i = 0; i < DRAIN_CYCLES && drive_q.size() != 0; i++) @(posedge clock);
      if (drive_q.size() != 0) begin
         flag_failure($sformatf("%0d responses never arrived", drive_q.size()));
         drive_q.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Default gains: ramp into the upper clamp, error zero, a hard negative
   // step into the lower clamp, zero target (drive off), then a small error.
   task automatic test_reset_defaults();
      send_beat('0, MAX_SPEED, 0);
      send_beat('0, MAX_SPEED, 0);
      send_beat('0, MAX_SPEED, 0);
      send_beat(MAX_SPEED, MAX_SPEED, 0);
      send_beat(MAX_SPEED, 1, 2);
      send_beat('0, '0, 0);
      send_beat(MAX_SPEED, '0, 0);
      send_beat(2000, 2100, 1);
      send_beat(2000, 2100, 0);
      drain_and_idle();
   endtask

   // Register extremes: full-scale gains with the most negative start
   // value (upper data bits set, must be ignored), then zero gains with
   // the most positive start. A spare index write must change nothing.
   task automatic test_register_extremes();
      write_csr(CSR_PROP_GAIN, '1);
      write_csr(CSR_DERIV_GAIN, '1);
      write_csr(CSR_START_PREV_ERROR, 24'hFFF000);
      write_csr(CSR_SPARE_INDEX, 24'h5A5A5A);
      send_beat('0, 1, 0);
      send_beat(1, '0, 0);
      send_beat('0, MAX_SPEED, 0);
      send_beat(MAX_SPEED, 1, 0);
      send_beat(MAX_SPEED, '0, 0);
      drain_and_idle();
      write_csr(CSR_PROP_GAIN, '0);
      write_csr(CSR_DERIV_GAIN, '0);
      write_csr(CSR_START_PREV_ERROR, 24'h000FFF);
      send_beat('0, MAX_SPEED, 0);
      send_beat(MAX_SPEED, 1, 0);
      send_beat(5, '0, 0);
      drain_and_idle();
   endtask

   // A start value write must not touch the running prev error; it only
   // lands at the next zero target.
   task automatic test_start_value_hold();
      write_csr(CSR_PROP_GAIN, 24'h100000);
      write_csr(CSR_DERIV_GAIN, 24'h400000);
      send_beat(100, 200, 0);
      drain_and_idle();
      write_csr(CSR_START_PREV_ERROR, '0);
      send_beat(150, 200, 0);
      send_beat(200, '0, 0);
      send_beat(100, 200, 0);
      drain_and_idle();
   endtask

   function automatic logic [GAIN_BITS-1:0] pick_gain();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return GAIN_BITS'($urandom_range(0, 1 << 18));
      if (r < 80) return GAIN_BITS'($urandom_range(0, 1 << 22));
      return GAIN_BITS'($urandom);
   endfunction

   function automatic logic [SPEED_BITS-1:0] pick_target();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return SPEED_BITS'(MAX_SPEED);
      if (r == 1) return SPEED_BITS'(1);
      return SPEED_BITS'($urandom_range(1, MAX_SPEED));
   endfunction

   // Random phases, each with its own register setting. Most beats track a
   // held target with the measurement scattered around it, so the drive
   // settles in mid range; the rest is noise and drive-off beats.
   task automatic test_random_traffic();
      int                    sent;
      int                    seg_len;
      int                    kind;
      int                    spread;
      int                    meas_i;
      logic [SPEED_BITS-1:0] tgt;
      logic [SPEED_BITS-1:0] meas;
      for (int phase = 0; phase < RUN_PHASES; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_PROP_GAIN, PROP_GAIN_RESET);
               write_csr(CSR_DERIV_GAIN, DERIV_GAIN_RESET);
               write_csr(CSR_START_PREV_ERROR, CSR_DATA_BITS'(START_PREV_ERROR_RESET));
            end
            1: begin
               write_csr(CSR_PROP_GAIN, '1);
               write_csr(CSR_DERIV_GAIN, '1);
               write_csr(CSR_START_PREV_ERROR, {11'($urandom), 13'h0FFF});
            end
            2: begin
               write_csr(CSR_PROP_GAIN, '0);
               write_csr(CSR_DERIV_GAIN, '0);
               write_csr(CSR_START_PREV_ERROR, {11'($urandom), 13'h1000});
            end
            default: begin
               write_csr(CSR_DERIV_GAIN, pick_gain());
               write_csr(CSR_START_PREV_ERROR, CSR_DATA_BITS'($urandom));
               write_csr(CSR_PROP_GAIN, pick_gain());
            end
         endcase
         if ($urandom_range(0, 2) == 0) begin
            write_csr(CSR_SPARE_INDEX, CSR_DATA_BITS'($urandom));
         end
         sent = 0;
         while (sent < PHASE_BEATS) begin
            no_req_gaps = ($urandom_range(0, 3) == 0);
            seg_len     = $urandom_range(4, 30);
            kind        = $urandom_range(0, 99);
            tgt         = pick_target();
            case ($urandom_range(0, 2))
               0:       spread = 4;
               1:       spread = 64;
               default: spread = 1024;
            endcase
            for (int k = 0; k < seg_len && sent < PHASE_BEATS; k++) begin
               if (kind < 15) begin
                  // pure noise
                  meas = SPEED_BITS'($urandom);
                  tgt  = SPEED_BITS'($urandom);
               end else begin
                  meas_i = int'(tgt) + int'($urandom_range(0, 2 * spread)) - spread;
                  if (meas_i < 0) meas_i = 0;
                  if (meas_i > MAX_SPEED) meas_i = MAX_SPEED;
                  meas = SPEED_BITS'(meas_i);
               end
               // drive-off beats cut into the tracking runs
               if ((kind < 25 && $urandom_range(0, 2) == 0) || $urandom_range(0, 19) == 0) begin
                  send_beat(meas, '0, pick_req_gap());
               end else begin
                  send_beat(meas, tgt, pick_req_gap());
               end
               sent++;
            end
         end
         no_req_gaps = 1'b0;
         drain_and_idle();
      end
   endtask

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   initial begin
      model_reset();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_register_extremes();
      test_start_value_hold();
      test_random_traffic();
      drain_and_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Hard stop in case a handshake never completes
   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- incremental_pd_velocity_control.f -----
src/pdvc_pkg.sv
src/pdvc_csr.sv
src/pdvc_datapath.sv
src/incremental_pd_velocity_control.sv
sim/incremental_pd_velocity_control_tb.sv
